// ===== rtl/core/audio_beat_phrase_tracker_assert.svh =====
// Assertion shorthands for the beat and phrase tracker checks.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef AUDIO_BEAT_PHRASE_TRACKER_ASSERT_SVH
`define AUDIO_BEAT_PHRASE_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abpt check failed");

// Consequent must hold in the cycle after the antecedent.
`define ABPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abpt check failed");

`endif

// ===== rtl/core/abpt_pkg.sv =====
`timescale 1ns / 1ps

package abpt_pkg;

    localparam int WINDOW_DEPTH         = 64;
    localparam int THRESHOLD_PERCENTILE = 93;

    localparam int QUARTER_DEPTH = WINDOW_DEPTH / 4;
    localparam int PCT_CLAMPED   = (THRESHOLD_PERCENTILE > 100) ? 100 : THRESHOLD_PERCENTILE;
    localparam int PCT_INDEX     = (PCT_CLAMPED * (WINDOW_DEPTH - 1)) / 100;
    localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W         = $clog2(QUARTER_DEPTH);

    localparam int VOL_W = 16;
    localparam int FIX_W = 32;

    // fold weights, 16 fraction bits
    localparam logic [15:0] W_THR_BEAT  = 16'd58982;
    localparam logic [15:0] W_THR_OTHER = 16'd64881;
    localparam logic [15:0] W_LAG_UP    = 16'd1311;
    localparam logic [15:0] W_LAG_DOWN  = 16'd39322;

    // configuration port
    localparam int NUM_REGS = 3;
    localparam int APB_AW   = $clog2(NUM_REGS * 4);
    localparam logic [APB_AW-3:0] REG_BEAT_FROM_AUDIO = 2'd0;
    localparam logic [APB_AW-3:0] REG_BEAT_TO_BREAK   = 2'd1;
    localparam logic [APB_AW-3:0] REG_SUSTAINED_BREAK = 2'd2;

    typedef enum logic [1:0] {
        PH_BEAT      = 2'd0,
        PH_BREAK     = 2'd1,
        PH_SUSTAINED = 2'd2
    } phrase_t;

    // sorted cell value: top bit marks the empty slot left by a delete
    typedef logic [VOL_W:0] sort_val_t;
    localparam sort_val_t SORT_INF = {1'b1, {VOL_W{1'b0}}};

    typedef struct packed {
        logic             del;
        logic             ins;
        logic [VOL_W-1:0] key;
    } sort_cmd_t;

endpackage

// ===== rtl/core/abpt_stream_if.sv =====
`timescale 1ns / 1ps

interface abpt_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] band_volume;
    logic [31:0] time_ms;
    logic        external_beat;

    modport source (output valid, band_volume, time_ms, external_beat, input ready);
    modport sink   (input valid, band_volume, time_ms, external_beat, output ready);
endinterface

interface abpt_result_if;
    logic        valid;
    logic        ready;
    logic        beat_active;
    logic        beat_onset;
    logic [1:0]  phrase_state;
    logic        phrase_changed;
    logic [15:0] smoothed_volume;
    logic [15:0] threshold_now;

    modport source (output valid, beat_active, beat_onset, phrase_state, phrase_changed,
                    smoothed_volume, threshold_now, input ready);
    modport sink   (input valid, beat_active, beat_onset, phrase_state, phrase_changed,
                    smoothed_volume, threshold_now, output ready);
endinterface

// ===== rtl/core/audio_beat_phrase_tracker.sv =====
`timescale 1ns / 1ps

// Beat and phrase tracker for one audio band. Each frame request (band volume,
// millisecond time, external beat flag) yields one result request: beat level,
// beat onset, phrase state (BEAT, BREAK, SUSTAINED_BREAK), phrase change flag,
// the integer part of the asymmetric lagging volume and of the adaptive beat
// threshold. Every WINDOW_DEPTH/4-th frame (an analysis frame) also passes
// S_TMUL and S_TADD, because it folds the percentile entry of the sorted
// window into the threshold. Every frame passes S_DEL, where the sorted cell
// chain drops the evicted volume, and then S_INS, where it inserts the new
// one; the single fold multiplier unit serves the lagging volume and then the
// threshold. The result register lets the next frame enter while a result
// still waits at the output. There is no clearing pass after reset: the
// window keeps a fill flag and the cells reset to zero directly. Registers
// (APB, byte address 4*i): beat_from_audio, beat_to_break_ms,
// sustained_break_ms; write them only while the block idles.
module audio_beat_phrase_tracker
    import abpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    abpt_frame_if.sink         frame,
    abpt_result_if.source      result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_TMUL,
        S_TADD,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic        cfg_audio_reg;
    logic [15:0] cfg_b2b_reg;
    logic [15:0] cfg_sus_reg;
    logic        cfg_wr;

    // captured frame
    logic [VOL_W-1:0] vol_reg;
    logic [31:0]      t_reg;
    logic             ext_reg;

    // tracker state
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             analysis_reg;
    logic [FIX_W-1:0] thr_reg;
    logic [FIX_W-1:0] lag_reg;
    logic             beat_reg;
    logic             onset_reg;
    logic             chg_reg;
    phrase_t          phrase_reg;
    phrase_t          phrase_next;
    logic [31:0]      last_beat_reg;
    logic [31:0]      last_change_reg;

    // result register
    logic             res_valid_reg;
    logic             res_beat_reg;
    logic             res_onset_reg;
    logic [1:0]       res_phrase_reg;
    logic             res_chg_reg;
    logic [15:0]      res_smooth_reg;
    logic [15:0]      res_thr_reg;

    logic             accept;
    logic             out_free;
    logic [FIX_W-1:0] vol_hi;
    logic             lag_rising;
    logic             beat_now;
    logic [31:0]      last_beat_eff;
    logic [31:0]      since_beat;
    logic [31:0]      since_change;

    logic [VOL_W-1:0] evict_data;
    logic [VOL_W-1:0] pct_value;
    sort_cmd_t        sort_cmd;

    logic             fold_load;
    logic [VOL_W-1:0] fold_vol;
    logic [FIX_W-1:0] fold_prev;
    logic [15:0]      fold_w;
    logic [FIX_W-1:0] fold_result;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_audio_reg <= 1'b1;
            cfg_b2b_reg   <= 16'd1000;
            cfg_sus_reg   <= 16'd8000;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[APB_AW-1:2])
                REG_BEAT_FROM_AUDIO: cfg_audio_reg <= pwdata[0];
                REG_BEAT_TO_BREAK:   cfg_b2b_reg   <= pwdata[15:0];
                REG_SUSTAINED_BREAK: cfg_sus_reg   <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[APB_AW-1:2])
            REG_BEAT_FROM_AUDIO: prdata = {31'b0, cfg_audio_reg};
            REG_BEAT_TO_BREAK:   prdata = {16'b0, cfg_b2b_reg};
            REG_SUSTAINED_BREAK: prdata = {16'b0, cfg_sus_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    // the result register frees when empty or when its request is taken now
    assign out_free    = !res_valid_reg || result.ready;
    assign frame.ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign accept      = frame.valid && frame.ready;

    assign result.valid           = res_valid_reg;
    assign result.beat_active     = res_beat_reg;
    assign result.beat_onset      = res_onset_reg;
    assign result.phrase_state    = res_phrase_reg;
    assign result.phrase_changed  = res_chg_reg;
    assign result.smoothed_volume = res_smooth_reg;
    assign result.threshold_now   = res_thr_reg;

    // ---------------------------------------------------------------
    // window and sorted chain
    // ---------------------------------------------------------------
    abpt_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (frame.band_volume),
        .evict_data (evict_data)
    );

    // drop the evicted volume, then insert the new one
    always_comb
    begin
        sort_cmd.del = (state_reg == S_DEL);
        sort_cmd.ins = (state_reg == S_INS);
        sort_cmd.key = (state_reg == S_DEL) ? evict_data : vol_reg;
    end

    abpt_sort_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (sort_cmd),
        .pct_value (pct_value)
    );

    // ---------------------------------------------------------------
    // shared fold unit: lagging volume in S_DEL, threshold in S_TMUL
    // ---------------------------------------------------------------
    assign vol_hi     = {vol_reg, 16'b0};
    assign lag_rising = vol_hi > lag_reg;

    always_comb
    begin
        fold_load = (state_reg == S_DEL) || (state_reg == S_TMUL);
        if (state_reg == S_TMUL)
        begin
            fold_vol  = pct_value;
            fold_prev = thr_reg;
            fold_w    = (phrase_reg == PH_BEAT) ? W_THR_BEAT : W_THR_OTHER;
        end
        else
        begin
            fold_vol  = vol_reg;
            fold_prev = lag_reg;
            fold_w    = lag_rising ? W_LAG_UP : W_LAG_DOWN;
        end
    end

    abpt_fold u_fold (
        .clk    (clk),
        .load   (fold_load),
        .vol    (fold_vol),
        .prev   (fold_prev),
        .weight (fold_w),
        .result (fold_result)
    );

    // ---------------------------------------------------------------
    // beat detection and phrase machine (evaluated in S_DEL)
    // ---------------------------------------------------------------
    assign cnt_next = (cnt_reg == CNT_W'(QUARTER_DEPTH - 1)) ? '0 : cnt_reg + 1'b1;

    assign beat_now = cfg_audio_reg ? (vol_hi >= thr_reg) : ext_reg;

    // an audio beat refreshes the beat time before the timeout check
    assign last_beat_eff = (cfg_audio_reg && beat_now) ? t_reg : last_beat_reg;
    assign since_beat    = t_reg - last_beat_eff;
    assign since_change  = t_reg - last_change_reg;

    always_comb
    begin
        phrase_next = phrase_reg;
        unique case (phrase_reg)
            PH_BEAT:
            begin
                if (analysis_reg && (since_beat > {16'b0, cfg_b2b_reg}))
                begin
                    phrase_next = PH_BREAK;
                end
            end
            PH_BREAK:
            begin
                if (beat_now)
                begin
                    phrase_next = PH_BEAT;
                end
                else if (since_change > {16'b0, cfg_sus_reg})
                begin
                    phrase_next = PH_SUSTAINED;
                end
            end
            PH_SUSTAINED:
            begin
                if (beat_now)
                begin
                    phrase_next = PH_BEAT;
                end
            end
            default:
            begin
                phrase_next = phrase_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer, tracker state and result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            vol_reg         <= '0;
            t_reg           <= '0;
            ext_reg         <= 1'b0;
            cnt_reg         <= '0;
            analysis_reg    <= 1'b0;
            thr_reg         <= '0;
            lag_reg         <= '0;
            beat_reg        <= 1'b0;
            onset_reg       <= 1'b0;
            chg_reg         <= 1'b0;
            phrase_reg      <= PH_BEAT;
            last_beat_reg   <= '0;
            last_change_reg <= '0;
            res_valid_reg   <= 1'b0;
            res_beat_reg    <= 1'b0;
            res_onset_reg   <= 1'b0;
            res_phrase_reg  <= PH_BEAT;
            res_chg_reg     <= 1'b0;
            res_smooth_reg  <= '0;
            res_thr_reg     <= '0;
        end
        else
        begin
            // capture a new frame and count it
            if (accept)
            begin
                vol_reg      <= frame.band_volume;
                t_reg        <= frame.time_ms;
                ext_reg      <= frame.external_beat;
                cnt_reg      <= cnt_next;
                analysis_reg <= (cnt_next == '0);
            end

            // drop a taken result unless a new one loads
            if ((state_reg == S_DONE) && out_free)
            begin
                res_valid_reg  <= 1'b1;
                res_beat_reg   <= beat_reg;
                res_onset_reg  <= onset_reg;
                res_phrase_reg <= phrase_reg;
                res_chg_reg    <= chg_reg;
                res_smooth_reg <= lag_reg[31:16];
                res_thr_reg    <= thr_reg[31:16];
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_DEL;
                    end
                end
                S_DEL:
                begin
                    beat_reg   <= beat_now;
                    onset_reg  <= beat_now && !beat_reg;
                    chg_reg    <= (phrase_next != phrase_reg);
                    phrase_reg <= phrase_next;
                    if (cfg_audio_reg && beat_now)
                    begin
                        last_beat_reg <= t_reg;
                    end
                    if (phrase_next != phrase_reg)
                    begin
                        last_change_reg <= t_reg;
                    end
                    state_reg <= S_INS;
                end
                S_INS:
                begin
                    lag_reg   <= fold_result;
                    state_reg <= analysis_reg ? S_TMUL : S_DONE;
                end
                S_TMUL:
                begin
                    state_reg <= S_TADD;
                end
                S_TADD:
                begin
                    thr_reg   <= fold_result;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the result register frees; take the next frame at once
                    if (out_free)
                    begin
                        state_reg <= accept ? S_DEL : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/abpt_sort_cell.sv =====
`timescale 1ns / 1ps

module abpt_sort_cell
    import abpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sort_cmd_t cmd,
    input  sort_val_t below,
    input  sort_val_t above,
    output sort_val_t val
);

    sort_val_t val_reg;
    sort_val_t val_next;
    sort_val_t key;

    assign key = {1'b0, cmd.key};

    always_comb
    begin
        val_next = val_reg;
        priority if (cmd.del)
        begin
            // at or above the evicted value: close the gap from above
            if (val_reg >= key)
            begin
                val_next = above;
            end
        end
        else if (cmd.ins)
        begin
            // above the new value: open the gap, first such cell takes the key
            if (val_reg > key)
            begin
                val_next = (below > key) ? below : key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

// ===== rtl/core/abpt_sort_chain.sv =====
`timescale 1ns / 1ps

module abpt_sort_chain
    import abpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sort_cmd_t        cmd,
    output logic [VOL_W-1:0] pct_value
);

    sort_val_t vals [WINDOW_DEPTH];

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        sort_val_t below;
        sort_val_t above;

        if (i == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_mid_lo
            assign below = vals[i-1];
        end

        if (i == WINDOW_DEPTH - 1)
        begin : g_last
            assign above = SORT_INF;
        end
        else
        begin : g_mid_hi
            assign above = vals[i+1];
        end

        abpt_sort_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .below (below),
            .above (above),
            .val   (vals[i])
        );
    end

    assign pct_value = vals[PCT_INDEX][VOL_W-1:0];

endmodule

// ===== rtl/core/abpt_window.sv =====
`timescale 1ns / 1ps

module abpt_window
    import abpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [VOL_W-1:0] push_data,
    output logic [VOL_W-1:0] evict_data
);

    logic [VOL_W-1:0]  mem [WINDOW_DEPTH];
    logic [WIN_AW-1:0] wp_reg;
    logic              full_reg;
    logic [VOL_W-1:0]  rd_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            rd_valid_reg <= full_reg;
            if (wp_reg == WIN_AW'(WINDOW_DEPTH - 1))
            begin
                wp_reg   <= '0;
                full_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    // read the oldest entry and overwrite it in the same cycle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rd_reg      <= mem[wp_reg];
            mem[wp_reg] <= push_data;
        end
    end

    // entries not yet written since reset read as zero
    assign evict_data = rd_valid_reg ? rd_reg : '0;

endmodule

// ===== rtl/core/abpt_fold.sv =====
`timescale 1ns / 1ps

module abpt_fold
    import abpt_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic [VOL_W-1:0] vol,
    input  logic [FIX_W-1:0] prev,
    input  logic [15:0]      weight,
    output logic [FIX_W-1:0] result
);

    logic [16:0] inv_w;
    logic [32:0] p_new_full;
    logic [47:0] p_old_full;
    logic [31:0] p_new_reg;
    logic [47:0] p_old_reg;
    logic [47:0] p_old_rnd;

    assign inv_w      = 17'h10000 - {1'b0, weight};
    assign p_new_full = {17'b0, vol} * {16'b0, inv_w};
    assign p_old_full = {16'b0, prev} * {32'b0, weight};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_new_reg <= p_new_full[31:0];
            p_old_reg <= p_old_full;
        end
    end

    // round half up on the old term; the new term needs no rounding, its 16 fraction bits match the result
    assign p_old_rnd = p_old_reg + 48'd32768;
    assign result    = p_new_reg + p_old_rnd[47:16];

endmodule

// ===== rtl/core/abpt_checker.sv =====
`timescale 1ns / 1ps

`include "audio_beat_phrase_tracker_assert.svh"

module abpt_checker
    import abpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    input  logic              frame_ready,
    input  logic              result_valid,
    input  logic              result_ready,
    input  logic              beat_active,
    input  logic              beat_onset,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata
);

    logic wr_b2b;

    assign wr_b2b = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_BEAT_TO_BREAK);

    // a stalled result request stays up
    `ABPT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)

    // an onset is always a beat
    `ABPT_ASSERT_SAME(a_onset_beat, result_valid && beat_onset, beat_active)

    // a frame is never taken in the cycle right after another
    `ABPT_ASSERT_NEXT(a_frame_busy, frame_valid && frame_ready, !frame_ready)

    // a written timeout reads back on the next cycle
    `ABPT_ASSERT_NEXT(a_cfg_readback, wr_b2b, (paddr[APB_AW-1:2] != REG_BEAT_TO_BREAK) || ((prdata[15:0] == $past(pwdata[15:0])) && (prdata[31:16] == 16'd0)))

endmodule

bind audio_beat_phrase_tracker abpt_checker u_abpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .beat_active  (result.beat_active),
    .beat_onset   (result.beat_onset),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import abpt_pkg::*;

    localparam int   HALF_PERIOD   = 5;
    localparam int   RESET_CYCLES  = 9;
    localparam int   PHASE_FRAMES  = 150;
    localparam int   NUM_PHASES    = 6;
    localparam int   IDLE_PCT      = 15;
    localparam int   HOLD_AT       = 400;     // frames accepted before the output hold
    localparam int   HOLD_CYCLES   = 200;
    localparam int   DRAIN_LIMIT   = 20000;
    localparam int   DRAIN_CYCLES  = 8;       // extra wait after the last result, keep margin
    localparam int   REPORT_MAX    = 10;
    localparam time  LIMIT_NS      = 3_000_000;

    // one frame request and the result request it should cause
    typedef struct packed {
        logic [15:0] volume;
        logic [31:0] stamp_ms;
        logic        ext_beat;
    } frame_t;

    typedef struct packed {
        logic        beat;
        logic        onset;
        phrase_t     phrase;
        logic        changed;
        logic [15:0] smooth;
        logic [15:0] thresh;
    } verdict_t;

    // directed rows: either a frame request or a register write
    typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [APB_AW-3:0] reg_idx;
        logic [15:0]       reg_val;
        frame_t            frame;
        logic              pinned;    // expected result typed into the row
        verdict_t          want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    abpt_frame_if  frame_bus ();
    abpt_result_if result_bus ();

    audio_beat_phrase_tracker u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Tracker state mirrored from the block, reset values as after rst_n
    // ------------------------------------------------------------------
    logic              cfg_audio     = 1'b1;
    logic [15:0]       cfg_to_break  = 16'd1000;
    logic [15:0]       cfg_sustain   = 16'd8000;

    logic [15:0]       vol_hist [WINDOW_DEPTH] = '{default: '0};
    logic [15:0]       ranked   [WINDOW_DEPTH] = '{default: '0};
    logic [WIN_AW-1:0] wr_ptr         = '0;
    logic [CNT_W-1:0]  frame_cnt      = '0;
    logic [31:0]       thr_fx         = '0;
    logic [31:0]       lag_fx         = '0;
    logic              prev_beat      = 1'b0;
    phrase_t           phrase         = PH_BEAT;
    logic [31:0]       last_beat_ms   = '0;
    logic [31:0]       last_change_ms = '0;

    verdict_t          pending_verdicts [$];

    // run bookkeeping
    int unsigned faults        = 0;
    int unsigned frames_in     = 0;
    int unsigned results_seen  = 0;
    int unsigned n_analysis    = 0;
    int unsigned n_beats       = 0;
    int unsigned n_onsets      = 0;
    int unsigned n_to_break    = 0;
    int unsigned n_to_sustain  = 0;
    int unsigned n_to_beat     = 0;
    int unsigned n_settings    = 0;
    int unsigned stall_seen    = 0;

    // pacing shared between the sender and the receiver
    logic calm     = 1'b0;    // no random idling on either side
    logic hold_off = 1'b0;    // receiver holds ready low

    // random sequence state
    logic [31:0] clock_ms    = '0;
    int unsigned quiet_left  = 0;
    int unsigned beat_period = 4;
    int unsigned beat_step   = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // 16.16 exponential fold, round half up
    function automatic logic [31:0] fold_q16(logic [15:0] vol, logic [31:0] old,
                                             logic [15:0] w);
        logic [63:0] acc;
        acc = {32'd0, vol, 16'd0} * (64'd65536 - {48'd0, w})
            + {32'd0, old} * {48'd0, w} + 64'd32768;
        return acc[47:16];
    endfunction

    // Advance the mirrored tracker by one frame and return its result.
    function automatic verdict_t track_frame(frame_t f);
        verdict_t    v;
        logic        analysis;
        logic        beat;
        phrase_t     was;
        logic [31:0] vol_fx;
        logic [31:0] gap_ms;
        logic [15:0] key;
        int          i;
        int          j;

        vol_fx = {f.volume, 16'd0};

        // push into the window and count the frame
        vol_hist[wr_ptr] = f.volume;
        wr_ptr    = wr_ptr + 1'b1;
        frame_cnt = frame_cnt + 1'b1;
        analysis  = (frame_cnt == '0);

        // take a sorted copy on analysis frames
        if (analysis) begin
            n_analysis++;
            for (i = 0; i < WINDOW_DEPTH; i++) begin
                key = vol_hist[i];
                j   = i;
                while (j > 0 && ranked[j-1] > key) begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = key;
            end
        end

        // lagging volume rises fast and falls slowly
        lag_fx = fold_q16(f.volume, lag_fx, (vol_fx > lag_fx) ? W_LAG_UP : W_LAG_DOWN);

        // only audio beats refresh the beat time
        if (cfg_audio) begin
            beat = (vol_fx >= thr_fx);
            if (beat) last_beat_ms = f.stamp_ms;
        end else begin
            beat = f.ext_beat;
        end
        v.onset   = beat & ~prev_beat;
        prev_beat = beat;

        was = phrase;
        case (phrase)
            PH_BEAT: begin
                gap_ms = f.stamp_ms - last_beat_ms;
                if (analysis && gap_ms > {16'd0, cfg_to_break}) begin
                    phrase         = PH_BREAK;
                    last_change_ms = f.stamp_ms;
                end
            end
            PH_BREAK: begin
                gap_ms = f.stamp_ms - last_change_ms;
                if (beat) begin
                    phrase         = PH_BEAT;
                    last_change_ms = f.stamp_ms;
                end else if (gap_ms > {16'd0, cfg_sustain}) begin
                    phrase         = PH_SUSTAINED;
                    last_change_ms = f.stamp_ms;
                end
            end
            default: begin
                if (beat) begin
                    phrase         = PH_BEAT;
                    last_change_ms = f.stamp_ms;
                end
            end
        endcase

        // fold the percentile entry with the weight of the new phrase
        if (analysis)
            thr_fx = fold_q16(ranked[PCT_INDEX], thr_fx,
                              (phrase == PH_BEAT) ? W_THR_BEAT : W_THR_OTHER);

        if (beat) n_beats++;
        if (v.onset) n_onsets++;
        if (phrase != was) begin
            case (phrase)
                PH_BREAK:     n_to_break++;
                PH_SUSTAINED: n_to_sustain++;
                default:      n_to_beat++;
            endcase
        end

        v.beat    = beat;
        v.phrase  = phrase;
        v.changed = (phrase != was);
        v.smooth  = lag_fx[31:16];
        v.thresh  = thr_fx[31:16];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    function automatic string show(verdict_t v);
        return $sformatf("beat=%0b onset=%0b phrase=%0d chg=%0b smooth=%0d thr=%0d",
                         v.beat, v.onset, v.phrase, v.changed, v.smooth, v.thresh);
    endfunction

    function automatic void note_fault(string msg);
        faults++;
        if (faults <= REPORT_MAX) $display("[%0t] %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one frame request, hold it until accepted, then predict.
    task automatic push_frame(input frame_t f, input logic pinned, input verdict_t want);
        verdict_t calc;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            frame_bus.valid <= 1'b0;
            @(posedge clk);
        end
        frame_bus.valid         <= 1'b1;
        frame_bus.band_volume   <= f.volume;
        frame_bus.time_ms       <= f.stamp_ms;
        frame_bus.external_beat <= f.ext_beat;
        do @(posedge clk); while (!frame_bus.ready);
        calc = track_frame(f);
        pending_verdicts.push_back(pinned ? want : calc);
        frames_in++;
    endtask

    // Drop valid and wait until every expected result has come back,
    // then let the last frame clear the pipeline.
    task automatic settle();
        int spins;
        frame_bus.valid <= 1'b0;
        spins = 0;
        while (pending_verdicts.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge clk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read back on the same select.
    task automatic program_reg(input logic [APB_AW-3:0] idx, input logic [15:0] val);
        logic [31:0] back;
        logic [31:0] held;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_BEAT_FROM_AUDIO: begin
                cfg_audio = val[0];
                held      = {31'd0, val[0]};
            end
            REG_BEAT_TO_BREAK: begin
                cfg_to_break = val;
                held         = {16'd0, val};
            end
            default: begin
                cfg_sustain = val;
                held        = {16'd0, val};
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back !== held)
            note_fault($sformatf("register %0d reads 0x%08h, written 0x%08h", idx, back, held));
    endtask

    function automatic stim_row_t f_row(logic [15:0] vol, logic [31:0] t, logic ext,
                                        logic pinned = 1'b0, verdict_t want = '0);
        stim_row_t r;
        r.kind    = ROW_FRAME;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.frame   = '{vol, t, ext};
        r.pinned  = pinned;
        r.want    = want;
        return r;
    endfunction

    function automatic stim_row_t r_row(logic [APB_AW-3:0] idx, logic [15:0] val);
        stim_row_t r;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.frame   = '0;
        r.pinned  = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    // Random frames: mostly a running clock with a beat pattern of random
    // tempo, quiet stretches that let the phrase machine fall into a break,
    // long time jumps, and some pure noise requests.
    function automatic frame_t next_frame();
        frame_t      f;
        int unsigned r;
        logic        loud;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            f.volume   = 16'($urandom);
            f.stamp_ms = $urandom;
            f.ext_beat = 1'($urandom);
            clock_ms   = f.stamp_ms;
            return f;
        end
        if (r < 11)
            clock_ms += $urandom_range(500, 5000);
        else if (r < 13)
            clock_ms += $urandom_range(20000, 90000);
        else
            clock_ms += $urandom_range(5, 60);

        if (quiet_left == 0 && $urandom_range(0, 49) == 0)
            quiet_left = $urandom_range(20, 120);
        beat_step = (beat_step + 1) % beat_period;
        if (beat_step == 0 && $urandom_range(0, 7) == 0)
            beat_period = $urandom_range(3, 12);
        loud = (quiet_left == 0) && (beat_step == 0);

        if (quiet_left != 0) begin
            quiet_left--;
            f.volume = 16'($urandom_range(0, 3000));
        end else if (loud) begin
            f.volume = 16'($urandom_range(20000, 65535));
        end else begin
            f.volume = 16'($urandom_range(0, 8000));
        end
        f.stamp_ms = clock_ms;
        f.ext_beat = loud ^ ($urandom_range(0, 9) == 0);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Result side: check every accepted result, pace ready
    // ------------------------------------------------------------------
    initial begin : result_side
        verdict_t got;
        verdict_t want;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready) begin
                got.beat    = result_bus.beat_active;
                got.onset   = result_bus.beat_onset;
                got.phrase  = phrase_t'(result_bus.phrase_state);
                got.changed = result_bus.phrase_changed;
                got.smooth  = result_bus.smoothed_volume;
                got.thresh  = result_bus.threshold_now;
                results_seen++;
                if (pending_verdicts.size() == 0) begin
                    note_fault({"result with nothing expected: ", show(got)});
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got !== want)
                        note_fault($sformatf("result %0d\n    want %s\n    got  %s",
                                             results_seen, show(want), show(got)));
                end
            end
            if (hold_off && frame_bus.valid && !frame_bus.ready) stall_seen++;
            result_bus.ready <= !hold_off && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Hold the output off for a long stretch once traffic is flowing, so
    // the result register fills and the block pushes back on frames.
    initial begin : output_hold
        wait (frames_in >= HOLD_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Hard stop for a hung handshake.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", pending_verdicts.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t   dir_rows [$];
        stim_row_t   row;
        int unsigned ph;
        logic        set_audio;
        logic [15:0] set_break;
        logic [15:0] set_sustain;

        frame_bus.valid         <= 1'b0;
        frame_bus.band_volume   <= '0;
        frame_bus.time_ms       <= '0;
        frame_bus.external_beat <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the threshold is zero, so any volume beats. A silent
        // first frame is an onset with everything else still at zero; a
        // full-scale second frame lifts the lagging volume by 0.98 of its
        // range only, landing on 64224.
        dir_rows.push_back(f_row(16'h0000, 32'd0, 1'b0, 1'b1,
                                 '{1'b1, 1'b1, PH_BEAT, 1'b0, 16'd0, 16'd0}));
        dir_rows.push_back(f_row(16'hFFFF, 32'd1, 1'b0, 1'b1,
                                 '{1'b1, 1'b0, PH_BEAT, 1'b0, 16'd64224, 16'd0}));

        // Switch to the external flag with both timeouts at zero. The last
        // audio beat stays at 1 ms while time runs up to the wrap, so the
        // first analysis frame (the sixteenth) drops to a break, the next
        // quiet frame to a sustained break, and a flagged beat comes back.
        dir_rows.push_back(r_row(REG_BEAT_FROM_AUDIO, 16'd0));
        dir_rows.push_back(r_row(REG_BEAT_TO_BREAK,   16'd0));
        dir_rows.push_back(r_row(REG_SUSTAINED_BREAK, 16'd0));
        dir_rows.push_back(f_row(16'hFFFF, 32'hFFFF_FFF0, 1'b1));
        dir_rows.push_back(f_row(16'h0000, 32'hFFFF_FFF1, 1'b0));
        dir_rows.push_back(f_row(16'hAAAA, 32'hFFFF_FFF2, 1'b1));
        dir_rows.push_back(f_row(16'h5555, 32'hFFFF_FFF3, 1'b0));
        dir_rows.push_back(f_row(16'hFFFF, 32'hFFFF_FFF4, 1'b1));
        dir_rows.push_back(f_row(16'h8000, 32'hFFFF_FFF5, 1'b1));
        dir_rows.push_back(f_row(16'h7FFF, 32'hFFFF_FFF6, 1'b0));
        dir_rows.push_back(f_row(16'h0001, 32'hFFFF_FFF7, 1'b1));
        dir_rows.push_back(f_row(16'hFFFE, 32'hFFFF_FFF8, 1'b0));
        dir_rows.push_back(f_row(16'h1234, 32'hFFFF_FFF9, 1'b1));
        dir_rows.push_back(f_row(16'hEDCB, 32'hFFFF_FFFA, 1'b0));
        dir_rows.push_back(f_row(16'h0F0F, 32'hFFFF_FFFB, 1'b0));
        dir_rows.push_back(f_row(16'hF0F0, 32'hFFFF_FFFC, 1'b1));
        dir_rows.push_back(f_row(16'h4000, 32'hFFFF_FFFD, 1'b0));   // analysis frame
        dir_rows.push_back(f_row(16'h0100, 32'hFFFF_FFFE, 1'b0));
        dir_rows.push_back(f_row(16'hC000, 32'hFFFF_FFFF, 1'b1));
        dir_rows.push_back(f_row(16'h2000, 32'h0000_0000, 1'b1));
        dir_rows.push_back(f_row(16'h0000, 32'h0000_0001, 1'b0));
        dir_rows.push_back(f_row(16'hFFFF, 32'h0000_0002, 1'b1));

        n_settings++;
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_REG) begin
                settle();
                program_reg(row.reg_idx, row.reg_val);
            end else begin
                push_frame(row.frame, row.pinned, row.want);
            end
        end

        // Random phases, each under its own register setting. Phase 2 runs
        // with no idling on either side and overlaps the output hold.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    set_audio = 1'b1; set_break = 16'd1000; set_sustain = 16'd8000;
                end
                1: begin
                    set_audio   = 1'b0;
                    set_break   = 16'($urandom_range(200, 2000));
                    set_sustain = 16'($urandom_range(500, 6000));
                end
                2: begin
                    set_audio = 1'b1; set_break = 16'd0; set_sustain = 16'd0;
                end
                3: begin
                    set_audio = 1'b1; set_break = 16'hFFFF; set_sustain = 16'hFFFF;
                end
                4: begin
                    set_audio = 1'b0; set_break = 16'hFFFF; set_sustain = 16'd0;
                end
                default: begin
                    set_audio   = 1'b1;
                    set_break   = 16'($urandom_range(300, 3000));
                    set_sustain = 16'($urandom_range(1000, 10000));
                end
            endcase
            program_reg(REG_BEAT_FROM_AUDIO, {15'd0, set_audio});
            program_reg(REG_BEAT_TO_BREAK,   set_break);
            program_reg(REG_SUSTAINED_BREAK, set_sustain);
            n_settings++;
            calm <= (ph == 2);
            // start one phase just short of the time wrap
            clock_ms = (ph == 3) ? 32'hFFFF_F000 : $urandom;
            repeat (PHASE_FRAMES) push_frame(next_frame(), 1'b0, '0);
        end

        // drain and report
        settle();
        if (pending_verdicts.size() != 0)
            note_fault($sformatf("%0d expected results never arrived",
                                 pending_verdicts.size()));
        $display("covered %0d frames (%0d analysis) under %0d register settings, %0d results",
                 frames_in, n_analysis, n_settings, results_seen);
        $display("beats %0d, onsets %0d, to BREAK %0d, to SUSTAINED_BREAK %0d, to BEAT %0d, input stalled %0d cycles during output hold",
                 n_beats, n_onsets, n_to_break, n_to_sustain, n_to_beat, stall_seen);
        if (faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== audio_beat_phrase_tracker.f =====
+incdir+rtl/core
rtl/core/abpt_pkg.sv
rtl/core/abpt_stream_if.sv
rtl/core/abpt_sort_cell.sv
rtl/core/abpt_sort_chain.sv
rtl/core/abpt_window.sv
rtl/core/abpt_fold.sv
rtl/core/audio_beat_phrase_tracker.sv
rtl/core/abpt_checker.sv
tb/tb_top.sv
